// ===== rtl/core/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Used by the input register, the header parser and the top level.
// No dependencies.
package wsd_pkg;

    // Length codes in the second header byte that call for an extended length.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Byte counts of the extended length fields and of the masking key.
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;
    localparam logic [3:0] MASK_KEY_LEN = 4'd4;

    // Result status codes.
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TRAIL   = 3'd5
    } phase_t;

    // One input byte of the frame buffer.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } res_item_t;

endpackage

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer.
// Instantiates wsd_in_reg and wsd_parser; depends on wsd_pkg.
//
// Usage:
//   The slave channel carries one byte of a received frame buffer per
//   transfer, with s_tlast on the buffer's last byte. The master channel
//   gives the unmasked payload bytes of the frame; m_tlast marks the final
//   result of the frame. m_tuser holds the status: payload byte, empty
//   payload complete, or truncated frame. A buffer that ends inside a frame
//   gives one truncation result, and the payload already sent is to be
//   discarded. Bytes after a completed frame give no result.
//   Throughput is one byte per cycle while the master channel takes each
//   result. A result passes through the input register, then the parser
//   writes the result register. The 64-bit remaining-length decrement and
//   compare set the path between the two registers.
//   Reset (aresetn low, synchronous) empties both registers and returns
//   the parser to the first header byte; the parser also restarts after
//   every buffer's last byte. While m_tready is low with a result pending,
//   the input register holds one more byte and s_tready then falls.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] out_status
    output logic       m_tlast
);

    in_item_t  in_item;
    in_item_t  item;
    logic      item_valid;
    logic      item_take;
    res_item_t res;

    assign in_item = '{data: s_tdata, last: s_tlast};

    wsd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    wsd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = res.data;
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

// ===== rtl/core/wsd_in_reg.sv =====
// Input register of the WebSocket frame deframer.
// Holds one accepted byte until the parser takes it; depends on wsd_pkg.
module wsd_in_reg
    import wsd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    output in_item_t item,
    input  logic     item_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register can take a new transfer when it is empty or drains this cycle.
    assign in_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each accepted transfer.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/wsd_parser.sv =====
// Header parser, unmasking datapath and result register of the deframer.
// Consumes one byte per cycle from wsd_in_reg unless stalled; depends on wsd_pkg.
module wsd_parser
    import wsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      item_valid,
    input  in_item_t  item,
    output logic      item_take,
    output logic      res_valid,
    output res_item_t res,
    input  logic      res_ready
);

    phase_t      phase_reg,  phase_next;
    logic [3:0]  hidx_reg,   hidx_next;
    logic        mask_reg,   mask_next;
    logic [63:0] rem_reg,    rem_next;
    logic [1:0]  cnt_reg,    cnt_next;
    logic [31:0] key_reg,    key_next;
    logic        out_valid_reg;
    res_item_t   out_reg;

    logic        emit;
    res_item_t   res_next;
    logic [3:0]  hidx_dec;
    logic [63:0] ext_len;
    logic [7:0]  key_byte;
    logic        fin;

    // An item moves on when the result register is empty or being drained.
    assign item_take = item_valid && (!out_valid_reg || res_ready);

    assign hidx_dec = hidx_reg - 4'd1;
    assign ext_len  = {rem_reg[55:0], item.data};
    assign fin      = (rem_reg == 64'd1);

    // Key byte for the current payload position, first arrived key byte first.
    always_comb begin
        case (cnt_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next state of the parser for the byte being consumed.
    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        mask_next  = mask_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        case (phase_reg)
            PH_FIRST: begin
                phase_next = PH_SECOND;
            end
            PH_SECOND: begin
                mask_next = item.data[7];
                if (item.data[6:0] == LEN_CODE_EXT16) begin
                    phase_next = PH_EXTLEN;
                    hidx_next  = EXT16_BYTES;
                    rem_next   = 64'd0;
                end else if (item.data[6:0] == LEN_CODE_EXT64) begin
                    phase_next = PH_EXTLEN;
                    hidx_next  = EXT64_BYTES;
                    rem_next   = 64'd0;
                end else begin
                    rem_next = {57'd0, item.data[6:0]};
                    if (item.data[7]) begin
                        phase_next = PH_KEY;
                        hidx_next  = MASK_KEY_LEN;
                    end else if (item.data[6:0] == 7'd0) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                rem_next  = ext_len;
                hidx_next = hidx_dec;
                if (hidx_dec == 4'd0) begin
                    if (mask_reg) begin
                        phase_next = PH_KEY;
                        hidx_next  = MASK_KEY_LEN;
                    end else if (ext_len == 64'd0) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_KEY: begin
                key_next  = {key_reg[23:0], item.data};
                hidx_next = hidx_dec;
                if (hidx_dec == 4'd0) begin
                    phase_next = (rem_reg == 64'd0) ? PH_TRAIL : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                rem_next = rem_reg - 64'd1;
                cnt_next = cnt_reg + 2'd1;
                if (fin) begin
                    phase_next = PH_TRAIL;
                end
            end
            default: begin
            end
        endcase
        // The buffer's last byte returns the parser to the start of a frame.
        if (item.last) begin
            phase_next = PH_FIRST;
            hidx_next  = 4'd0;
            mask_next  = 1'b0;
            rem_next   = 64'd0;
            cnt_next   = 2'd0;
            key_next   = 32'd0;
        end
    end

    // Result produced by the byte being consumed.
    always_comb begin
        emit     = 1'b0;
        res_next = '{data: 8'd0, status: ST_EMPTY, last: 1'b1};
        case (phase_reg)
            PH_SECOND: begin
                if (item.data[6:0] == 7'd0 && !item.data[7]) begin
                    emit = 1'b1;
                end
            end
            PH_EXTLEN: begin
                if (hidx_dec == 4'd0 && !mask_reg && ext_len == 64'd0) begin
                    emit = 1'b1;
                end
            end
            PH_KEY: begin
                if (hidx_dec == 4'd0 && rem_reg == 64'd0) begin
                    emit = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                emit            = 1'b1;
                res_next.data   = mask_reg ? (item.data ^ key_byte) : item.data;
                res_next.status = ST_DATA;
                res_next.last   = fin;
            end
            default: begin
            end
        endcase
        // A buffer that ends inside a frame replaces any result with an error.
        if (item.last) begin
            if (!((phase_reg == PH_PAYLOAD && fin) || phase_reg == PH_TRAIL
                  || (emit && res_next.status == ST_EMPTY))) begin
                emit     = 1'b1;
                res_next = '{data: 8'd0, status: ST_TRUNC, last: 1'b1};
            end
        end
    end

    // Parser control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            hidx_reg  <= 4'd0;
            mask_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end else if (item_take) begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            mask_reg  <= mask_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Length and key registers, loaded before they are used in each frame.
    always_ff @(posedge aclk) begin
        if (item_take) begin
            rem_reg <= rem_next;
            key_reg <= key_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_take) begin
            out_valid_reg <= emit;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            out_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Status results other than payload bytes carry a zero byte.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.status != ST_DATA |-> out_reg.data == 8'd0)
        else $error("non-payload result carries a nonzero byte");

    // Empty and truncation results always close the frame.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.status == ST_EMPTY || out_reg.status == ST_TRUNC)
        |-> out_reg.last)
        else $error("status result without last flag");

    // The buffer's last byte always restarts the parser.
    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && item.last |=> phase_reg == PH_FIRST && hidx_reg == 4'd0)
        else $error("parser not restarted after last byte");

    // Payload phase is only entered with bytes still to come.
    a_payload_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> rem_reg != 64'd0)
        else $error("payload phase with no bytes remaining");

endmodule
